[src/deq_pkg.sv]
// Shared constants for the double-ended queue: sizes, command and status codes.
package deq_pkg;

	// default sizes
	localparam int DEQ_DEPTH      = 16;
	localparam int DEQ_DATA_WIDTH = 32;

	// field widths on the stream ports
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;
	// spare codes: no state change, status ok
	localparam logic [CMD_W-1:0] CMD_SPARE_LO   = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI   = 3'd7;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd3;

endpackage

[src/double_ended_queue.sv]
// Double-ended queue on a ring buffer with one shared ring-address adder and one memory port.
// Result word is registered after the sequencer steps through ELEM, UPDT, RDB, RDA, RDF, RDL, CAP and DONE.
// A new input word is taken only once the sequencer is back in idle; it walks up to five reads
// (element, neighbors, first, last) through the single slot read port and ring adder.
// Reset (arst_n low, asynchronous): queue empty, front pointer 0, sequencer idle,
// no result pending. Slot contents are not cleared; only slots inside the fill are read.
module double_ended_queue
	import deq_pkg::*;
#(
	parameter int DEPTH      = DEQ_DEPTH,
	parameter int DATA_WIDTH = DEQ_DATA_WIDTH,
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW        = $clog2(DEPTH + 1),
	localparam int IN_W      = ((WORD_W + POS_W + 7) / 8) * 8,
	localparam int OUT_BITS  = 6 * WORD_W - WORD_W + 3 + CW,
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [IN_W-1:0]     s_axis_tdata,  // value[31:0], position[47:32]
	input  logic [CMD_W-1:0]    s_axis_tuser,  // command[2:0]
	// result stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OUT_W-1:0]    m_axis_tdata,  // element, before_elem, before_ok, after_elem,
	                                           // after_ok, first_elem, last_elem, occupancy,
	                                           // is_empty, zero pad
	output logic [STATUS_W-1:0] m_axis_tuser   // status[1:0]
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_ELEM = 9'b000000010,
		S_UPDT = 9'b000000100,
		S_RDB  = 9'b000001000,
		S_RDA  = 9'b000010000,
		S_RDF  = 9'b000100000,
		S_RDL  = 9'b001000000,
		S_CAP  = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t                state_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [WORD_W-1:0]     value_q;
	logic [POS_W-1:0]      position_q;
	logic [STATUS_W-1:0]   status_q;
	logic [AW-1:0]         front_q;
	logic [CW-1:0]         fill_q;
	logic                  elem_rd_q;
	logic                  bok_q;
	logic                  aok_q;
	logic [WORD_W-1:0]     element_q;
	logic [WORD_W-1:0]     before_q;
	logic [WORD_W-1:0]     after_q;
	logic [WORD_W-1:0]     first_q;
	logic [WORD_W-1:0]     last_q;
	logic                  m_valid_q;
	logic [OUT_W-1:0]      m_data_q;
	logic [STATUS_W-1:0]   m_user_q;

	logic [DATA_WIDTH-1:0] slots_q [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic                  accept;
	logic                  out_free;
	logic                  is_push;
	logic                  is_pop;
	logic                  not_empty;
	logic                  is_full;
	logic [CW-1:0]         pos_c;
	logic                  query_good;
	logic                  aft_exists;
	logic [STATUS_W-1:0]   status_d;
	logic [CW-1:0]         ring_off;
	logic [CW:0]           ring_raw;
	logic [CW:0]           ring_sum;
	logic [AW-1:0]         ring_addr;
	logic [DATA_WIDTH+WORD_W-1:0] wr_ext;
	logic [DATA_WIDTH-1:0]        wr_data;
	logic [DATA_WIDTH+WORD_W-1:0] rd_ext;
	logic [WORD_W-1:0]            rd_word;
	logic                  wr_en;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign out_free      = !m_valid_q || m_axis_tready;

	// command decode against current queue state
	assign is_push    = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_BACK);
	assign is_pop     = (cmd_q == CMD_POP_FRONT) || (cmd_q == CMD_POP_BACK);
	assign not_empty  = (fill_q != '0);
	assign is_full    = (fill_q == CW'(DEPTH));
	assign pos_c      = position_q[CW-1:0];
	assign query_good = !position_q[POS_W-1] && (position_q < POS_W'(fill_q));
	assign aft_exists = (CW'(pos_c + 1'b1) < fill_q);

	always_comb begin
		status_d = ST_OK;
		unique case (cmd_q) inside
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (is_full) status_d = ST_FULL;
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (!not_empty) status_d = ST_EMPTY;
			end
			CMD_QUERY: begin
				if (!query_good) status_d = ST_BAD_IDX;
			end
			default: status_d = ST_OK;
		endcase
	end

	// offset into the ring for this step
	always_comb begin
		ring_off = '0;
		unique case (state_q)
			S_ELEM: begin
				if (cmd_q == CMD_POP_BACK) ring_off = CW'(fill_q - 1'b1);
				else if (cmd_q == CMD_QUERY) ring_off = pos_c;
			end
			S_UPDT: begin
				if (cmd_q == CMD_PUSH_FRONT) ring_off = CW'(DEPTH - 1);
				else if (cmd_q == CMD_PUSH_BACK) ring_off = fill_q;
				else if (cmd_q == CMD_POP_FRONT) ring_off = CW'(1);
			end
			S_RDB:   ring_off = CW'(pos_c - 1'b1);
			S_RDA:   ring_off = CW'(pos_c + 1'b1);
			S_RDL:   ring_off = CW'(fill_q - 1'b1);
			default: ring_off = '0;
		endcase
	end

	// shared ring adder: front + offset, wrapped once
	assign ring_raw  = (CW+1)'(front_q) + (CW+1)'(ring_off);
	assign ring_sum  = (ring_raw >= (CW+1)'(DEPTH)) ? (ring_raw - (CW+1)'(DEPTH)) : ring_raw;
	assign ring_addr = ring_sum[AW-1:0];

	// data width adaptation
	assign wr_ext  = {{DATA_WIDTH{1'b0}}, value_q};
	assign wr_data = wr_ext[DATA_WIDTH-1:0];
	assign rd_ext  = {{WORD_W{1'b0}}, rdata_q};
	assign rd_word = rd_ext[WORD_W-1:0];
	assign wr_en   = (state_q == S_UPDT) && is_push && !is_full;

	// slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) slots_q[ring_addr] <= wr_data;
		rdata_q <= slots_q[ring_addr];
	end

	// sequencer and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			front_q   <= '0;
			fill_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// result valid: set on leaving done, cleared once taken
			if (state_q == S_DONE && out_free) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_ELEM;
				end
				S_ELEM: state_q <= S_UPDT;
				S_UPDT: begin
					state_q <= S_RDB;
					if (status_q == ST_OK) begin
						case (cmd_q)
							CMD_PUSH_FRONT: begin
								front_q <= ring_addr;
								fill_q  <= CW'(fill_q + 1'b1);
							end
							CMD_PUSH_BACK: fill_q <= CW'(fill_q + 1'b1);
							CMD_POP_FRONT: begin
								front_q <= ring_addr;
								fill_q  <= CW'(fill_q - 1'b1);
							end
							CMD_POP_BACK: fill_q <= CW'(fill_q - 1'b1);
							CMD_CLEAR: begin
								front_q <= '0;
								fill_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				S_RDB: state_q <= S_RDA;
				S_RDA: state_q <= S_RDF;
				S_RDF: state_q <= S_RDL;
				S_RDL: state_q <= S_CAP;
				S_CAP: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-item working registers and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= s_axis_tuser;
			value_q    <= s_axis_tdata[WORD_W-1:0];
			position_q <= s_axis_tdata[WORD_W+POS_W-1:WORD_W];
		end
		unique case (state_q)
			S_ELEM: begin
				status_q  <= status_d;
				elem_rd_q <= (is_pop && not_empty) || ((cmd_q == CMD_QUERY) && query_good);
			end
			S_UPDT: element_q <= elem_rd_q ? rd_word : '0;
			S_RDB:  bok_q <= (cmd_q == CMD_QUERY) && query_good && (pos_c != '0);
			S_RDA: begin
				before_q <= bok_q ? rd_word : '0;
				aok_q    <= (cmd_q == CMD_QUERY) && query_good && aft_exists;
			end
			S_RDF:  after_q <= aok_q ? rd_word : '0;
			S_RDL:  first_q <= not_empty ? rd_word : '0;
			S_CAP:  last_q <= not_empty ? rd_word : '0;
			S_DONE: begin
				if (out_free) begin
					m_user_q <= status_q;
					m_data_q <= OUT_W'({!not_empty, fill_q, last_q, first_q, aok_q, after_q,
						bok_q, before_q, element_q});
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

`ifndef ASSERT_OFF
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	a_front_range: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= AW'(DEPTH - 1))
		else $error("front pointer beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDT && status_q == ST_OK && is_push) |=>
		(fill_q == CW'($past(fill_q) + 1'b1)))
		else $error("accepted push did not grow the fill");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDT && status_q == ST_OK && is_pop) |=>
		(fill_q == CW'($past(fill_q) - 1'b1)))
		else $error("accepted pop did not shrink the fill");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (m_valid_q && state_q == S_IDLE))
		else $error("result word not posted on leaving done");
`endif

endmodule
